@@ rtl/arpc_pkg.sv @@
`default_nettype none
package arpc_pkg;

  localparam int unsigned InDataW  = 208;
  localparam int unsigned OutDataW = 216;

  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  localparam logic [15:0] ARP_MIN_LEN = 16'd28;
  localparam logic [15:0] HT_ETHER    = 16'h0001;
  localparam logic [15:0] PT_IPV4     = 16'h0800;
  localparam logic [15:0] RX_OP_REQ   = 16'h0001;
  localparam logic [1:0]  ARP_OP_REQ  = 2'd1;
  localparam logic [1:0]  ARP_OP_REP  = 2'd2;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_DROP  = 3'd0,
    KIND_LEARN = 3'd1,
    KIND_REPLY = 3'd2,
    KIND_HIT   = 3'd3,
    KIND_MISS  = 3'd4,
    KIND_REQ   = 3'd5
  } kind_e;

  // Search token that walks the row of cache cells.
  typedef struct packed {
    logic        act;
    logic        learn;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        hit;
    logic [47:0] hit_mac;
  } tok_t;

endpackage
`default_nettype wire

@@ rtl/arpc_cell.sv @@
`default_nettype none
module arpc_cell (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  arpc_pkg::tok_t   tok_i,
  output arpc_pkg::tok_t   tok_o
);
  import arpc_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic        wr;
  logic        match;
  tok_t        tok_q, tok_d;

  assign match = valid_q && (ip_q == tok_i.ip);
  assign wr    = tok_i.act && tok_i.learn && !valid_q;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    if (tok_i.act) begin
      if (match) begin
        tok_d.hit     = 1'b1;
        tok_d.hit_mac = mac_q;
        tok_d.learn   = 1'b0;
      end else if (wr) begin
        valid_d     = 1'b1;
        tok_d.learn = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ip_q  <= tok_i.ip;
      mac_q <= tok_i.mac;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

@@ rtl/arpc_ctrl.sv @@
`default_nettype none
module arpc_ctrl (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire [31:0]                      local_ip_i,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // query_ip, pkt_length, pkt_arp_op, pkt_hw_type, pkt_proto_type,
  // pkt_sender_mac, pkt_sender_ip, pkt_target_ip
  input  wire [arpc_pkg::InDataW-1:0]     s_axis_tdata,
  // opcode
  input  wire [1:0]                       s_axis_tuser,
  output arpc_pkg::tok_t                  tok_o,
  input  arpc_pkg::tok_t                  tok_i,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // frame_dest_mac, frame_arp_op, frame_hw_type, frame_proto_type,
  // frame_target_mac, frame_target_ip, lookup_mac, zero pad
  output logic [arpc_pkg::OutDataW-1:0]   m_axis_tdata,
  // result_kind
  output logic [2:0]                      m_axis_tuser
);
  import arpc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [1:0]          opc_q;
  logic [InDataW-1:0]  in_q;
  tok_t                inj_q, inj_d;
  logic [OutDataW-1:0] odata_q, odata_d;
  kind_e               kind_q, kind_d;

  logic [31:0] qip, sip, tip;
  logic [15:0] len, rop, hwt, prt;
  logic [47:0] smac;
  logic        s_acc, rx_ok;
  logic [31:0] a_qip, a_tip;
  logic [15:0] a_len;
  logic [47:0] a_smac;
  logic [31:0] a_sip;

  assign qip  = in_q[31:0];
  assign len  = in_q[47:32];
  assign rop  = in_q[63:48];
  assign hwt  = in_q[79:64];
  assign prt  = in_q[95:80];
  assign smac = in_q[143:96];
  assign sip  = in_q[175:144];
  assign tip  = in_q[207:176];

  assign a_qip  = s_axis_tdata[31:0];
  assign a_len  = s_axis_tdata[47:32];
  assign a_smac = s_axis_tdata[143:96];
  assign a_sip  = s_axis_tdata[175:144];
  assign a_tip  = s_axis_tdata[207:176];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign rx_ok         = (len >= ARP_MIN_LEN) && (tip == local_ip_i);

  always_comb begin
    inj_d = '0;
    if (s_acc) begin
      inj_d.act   = 1'b1;
      inj_d.learn = (s_axis_tuser == OP_RECEIVE) && (a_len >= ARP_MIN_LEN) &&
                    (a_tip == local_ip_i);
      inj_d.ip    = (s_axis_tuser == OP_RECEIVE) ? a_sip : a_qip;
      inj_d.mac   = a_smac;
    end
  end

  always_comb begin
    odata_d = '0;
    kind_d  = KIND_DROP;
    unique case (opc_q)
      OP_RECEIVE: begin
        if (rx_ok) begin
          if (rop == RX_OP_REQ) begin
            kind_d           = KIND_REPLY;
            odata_d[47:0]    = smac;
            odata_d[49:48]   = ARP_OP_REP;
            odata_d[65:50]   = hwt;
            odata_d[81:66]   = prt;
            odata_d[129:82]  = smac;
            odata_d[161:130] = sip;
          end else begin
            kind_d = KIND_LEARN;
          end
        end
      end
      OP_LOOKUP: begin
        if (tok_i.hit) begin
          kind_d           = KIND_HIT;
          odata_d[209:162] = tok_i.hit_mac;
        end else begin
          kind_d = KIND_MISS;
        end
      end
      OP_REQUEST: begin
        kind_d           = KIND_REQ;
        odata_d[47:0]    = MAC_BCAST;
        odata_d[49:48]   = ARP_OP_REQ;
        odata_d[65:50]   = HT_ETHER;
        odata_d[81:66]   = PT_IPV4;
        odata_d[161:130] = qip;
      end
      default: kind_d = KIND_DROP;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_acc) state_d = ST_BUSY;
      ST_BUSY: if (tok_i.act) state_d = ST_OUT;
      ST_OUT:  if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      inj_q   <= '0;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q  <= s_axis_tdata;
      opc_q <= s_axis_tuser;
    end
    if (state_q == ST_BUSY && tok_i.act) begin
      odata_q <= odata_d;
      kind_q  <= kind_d;
    end
  end

  assign tok_o         = inj_q;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = kind_q;

  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.act |-> state_q == ST_BUSY)
    else $error("search token left the cell row while not busy");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inj_q.act |=> !inj_q.act)
    else $error("two search tokens injected back to back");

  a_out_after_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(tok_i.act))
    else $error("result shown without a finished search");

  a_inj_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inj_q.act |-> state_q == ST_BUSY)
    else $error("token injected outside a busy phase");

endmodule
`default_nettype wire

@@ rtl/arp_cache_responder.sv @@
`default_nettype none
// Every beat, whatever its opcode, sends one search token down a row of
// CACHE_ENTRIES cells, one cell per cycle.
// A new beat is taken only after the result of the last one has been taken.
// Asynchronous active-low reset clears all entries and both station registers.
module arp_cache_responder #(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [3:0]                      paddr,
  input  wire  [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // query_ip, pkt_length, pkt_arp_op, pkt_hw_type, pkt_proto_type,
  // pkt_sender_mac, pkt_sender_ip, pkt_target_ip
  input  wire  [arpc_pkg::InDataW-1:0]    s_axis_tdata,
  // opcode
  input  wire  [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // frame_dest_mac, frame_arp_op, frame_hw_type, frame_proto_type,
  // frame_target_mac, frame_target_ip, lookup_mac, zero pad
  output logic [arpc_pkg::OutDataW-1:0]   m_axis_tdata,
  // result_kind
  output logic [2:0]                      m_axis_tuser
);
  import arpc_pkg::*;

  logic [31:0] local_ip_q;
  logic [47:0] local_mac_q;
  logic        cfg_wr;
  tok_t        chain [CACHE_ENTRIES+1];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        local_mac_q <= pwdata[47:0];
      end else begin
        local_ip_q <= pwdata[31:0];
      end
    end
  end

  assign prdata = paddr[3] ? {16'd0, local_mac_q} : {32'd0, local_ip_q};

  arpc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .local_ip_i    (local_ip_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .tok_o         (chain[0]),
    .tok_i         (chain[CACHE_ENTRIES]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

endmodule
`default_nettype wire
